>>> hdl/assert_macros.svh
// Assertion macros for the flow hash RTL.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// a implies b in the same cycle
`define ASSERT_IMP(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// a implies b in the next cycle
`define ASSERT_NXT(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

>>> hdl/cid_pkg.sv
// Types, constants and functions for the Community ID flow hash.
// No dependencies; used by every module of the block.
package cid_pkg;

  localparam int IdLen  = 30;
  localparam int Rounds = 80;

  localparam logic [7:0] ProtoIcmp   = 8'd1;
  localparam logic [7:0] ProtoTcp    = 8'd6;
  localparam logic [7:0] ProtoUdp    = 8'd17;
  localparam logic [7:0] ProtoIcmp6  = 8'd58;
  localparam logic [7:0] ProtoSctp   = 8'd132;

  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharPad   = 8'h3D;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  typedef struct packed {
    logic        is_ipv6;
    logic [7:0]  ip_proto;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [15:0] src_port_in;
    logic [15:0] dst_port_in;
    logic [7:0]  icmp_type_in;
    logic [7:0]  icmp_code_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha_st_t;

  typedef logic [15:0][31:0] sha_win_t;

  // ICMPv4 request/reply pairing; one_way when the type has no partner
  function automatic logic [16:0] icmp4_pair(logic [7:0] ty, logic [7:0] code);
    logic [16:0] r;
    r = {1'b0, 16'd0};
    case (ty)
      8'd8:    r = {1'b0, 16'd0};
      8'd0:    r = {1'b0, 16'd8};
      8'd13:   r = {1'b0, 16'd14};
      8'd14:   r = {1'b0, 16'd13};
      8'd15:   r = {1'b0, 16'd16};
      8'd16:   r = {1'b0, 16'd15};
      8'd10:   r = {1'b0, 16'd9};
      8'd9:    r = {1'b0, 16'd10};
      8'd17:   r = {1'b0, 16'd18};
      8'd18:   r = {1'b0, 16'd17};
      default: r = {1'b1, 8'd0, code};
    endcase
    return r;
  endfunction

  // ICMPv6 request/reply pairing
  function automatic logic [16:0] icmp6_pair(logic [7:0] ty, logic [7:0] code);
    logic [16:0] r;
    r = {1'b0, 16'd0};
    case (ty)
      8'd128:  r = {1'b0, 16'd129};
      8'd129:  r = {1'b0, 16'd128};
      8'd133:  r = {1'b0, 16'd134};
      8'd134:  r = {1'b0, 16'd133};
      8'd135:  r = {1'b0, 16'd136};
      8'd136:  r = {1'b0, 16'd135};
      8'd130:  r = {1'b0, 16'd131};
      8'd131:  r = {1'b0, 16'd130};
      8'd139:  r = {1'b0, 16'd140};
      8'd140:  r = {1'b0, 16'd139};
      8'd144:  r = {1'b0, 16'd145};
      8'd145:  r = {1'b0, 16'd144};
      default: r = {1'b1, 8'd0, code};
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // one SHA-1 round; rnd is fixed per pipeline stage
  function automatic sha_st_t sha_round(sha_st_t s, logic [31:0] w, int rnd);
    logic [31:0] f;
    logic [31:0] k;
    sha_st_t     o;
    if (rnd < 20) begin
      f = (s.b & s.c) | (~s.b & s.d);
      k = 32'h5A827999;
    end else if (rnd < 40) begin
      f = s.b ^ s.c ^ s.d;
      k = 32'h6ED9EBA1;
    end else if (rnd < 60) begin
      f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
      k = 32'h8F1BBCDC;
    end else begin
      f = s.b ^ s.c ^ s.d;
      k = 32'hCA62C1D6;
    end
    o.a = rotl(s.a, 5) + f + s.e + k + w;
    o.b = s.a;
    o.c = rotl(s.b, 30);
    o.d = s.c;
    o.e = s.d;
    return o;
  endfunction

  // base64 alphabet
  function automatic logic [7:0] b64_char(logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26)      r = 8'h41 + {2'b00, v};
    else if (v < 6'd52) r = 8'h61 + {2'b00, v} - 8'd26;
    else if (v < 6'd62) r = 8'h30 + {2'b00, v} - 8'd52;
    else if (v == 6'd62) r = 8'h2B;
    else                r = 8'h2F;
    return r;
  endfunction

endpackage

>>> hdl/community_id_flow_hash.sv
// Top level of the Community ID v1 flow hash.
// Depends on cid_pkg, cid_prep, cid_sha1 and cid_b64.
//
//  channel | ports                          | word
//  input   | in_valid, in_ready, in_data    | cid_pkg::in_word_t, one flow tuple
//  result  | out_valid, out_ready, out_data | cid_pkg::out_word_t, one character
//
// Each tuple gives 30 result words, one per cycle while out_ready is high; the
// serialiser takes the next digest as the final character of the previous one goes.
// The first character follows two front stages, the block load, 80 round stages,
// the final add and the serialiser load.
// rst_n is synchronous and clears all valid bits. While a finished digest waits
// for the serialiser the whole pipeline holds, so nothing is lost or repeated.
module community_id_flow_hash (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cid_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cid_pkg::out_word_t out_data
);

  logic         en;
  logic         blk_v;
  logic [511:0] blk;
  logic         dig_v, dig_rdy;
  logic [159:0] dig;

  // pipeline advances unless a finished digest is waiting
  assign en       = !dig_v || dig_rdy;
  assign in_ready = en;

  cid_prep u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_valid),
    .in_d  (in_data),
    .blk_v (blk_v),
    .blk   (blk)
  );

  cid_sha1 u_sha1 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .blk_v (blk_v),
    .blk   (blk),
    .dig_v (dig_v),
    .dig   (dig)
  );

  cid_b64 u_b64 (
    .clk       (clk),
    .rst_n     (rst_n),
    .dig_v     (dig_v),
    .dig       (dig),
    .dig_rdy   (dig_rdy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> hdl/cid_prep.sv
// Front end: port mapping, endpoint ordering and SHA-1 block assembly.
// Two register stages; depends on cid_pkg.
module cid_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  cid_pkg::in_word_t in_d,
  output logic              blk_v,
  output logic [511:0]      blk
);

  // stage 1 registers
  logic         v1_r, v1_nxt;
  logic         v6_r;
  logic [7:0]   proto_r;
  logic [127:0] sa_r, da_r;
  logic [15:0]  sp_r, dp_r;
  logic         keep_r;
  // stage 2 registers
  logic         v2_r, v2_nxt;
  logic [511:0] blk_r, blk_nxt;

  logic [127:0] sa, da;
  logic [15:0]  sp, dp;
  logic [16:0]  pair;
  logic         one_way, less;

  // map ports and pick the endpoint order
  always_comb begin
    sp      = in_d.src_port_in;
    dp      = in_d.dst_port_in;
    one_way = 1'b0;
    pair    = cid_pkg::icmp4_pair(in_d.icmp_type_in, in_d.icmp_code_in);
    if (!in_d.is_ipv6 && in_d.ip_proto == cid_pkg::ProtoIcmp) begin
      sp      = {8'd0, in_d.icmp_type_in};
      dp      = pair[15:0];
      one_way = pair[16];
    end else if (in_d.is_ipv6 && in_d.ip_proto == cid_pkg::ProtoIcmp6) begin
      pair    = cid_pkg::icmp6_pair(in_d.icmp_type_in, in_d.icmp_code_in);
      sp      = {8'd0, in_d.icmp_type_in};
      dp      = pair[15:0];
      one_way = pair[16];
    end else if (!(in_d.ip_proto inside {cid_pkg::ProtoTcp, cid_pkg::ProtoUdp,
                                          cid_pkg::ProtoSctp})) begin
      sp = 16'd0;
      dp = 16'd0;
    end
    if (in_d.is_ipv6) begin
      sa = {in_d.src_addr_high, in_d.src_addr_low};
      da = {in_d.dst_addr_high, in_d.dst_addr_low};
    end else begin
      sa = {96'd0, in_d.src_addr_low[31:0]};
      da = {96'd0, in_d.dst_addr_low[31:0]};
    end
    if (sa != da) less = sa < da;
    else          less = sp < dp;
  end

  assign v1_nxt = in_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v6_r    <= in_d.is_ipv6;
      proto_r <= in_d.ip_proto;
      sa_r    <= sa;
      da_r    <= da;
      sp_r    <= sp;
      dp_r    <= dp;
      keep_r  <= one_way | less;
    end
  end

  // assemble the padded message block
  logic [127:0] a1, a2;
  logic [15:0]  p1, p2;
  logic         has_ports;

  always_comb begin
    a1        = keep_r ? sa_r : da_r;
    a2        = keep_r ? da_r : sa_r;
    p1        = keep_r ? sp_r : dp_r;
    p2        = keep_r ? dp_r : sp_r;
    has_ports = proto_r inside {cid_pkg::ProtoIcmp, cid_pkg::ProtoTcp, cid_pkg::ProtoUdp,
                                cid_pkg::ProtoIcmp6, cid_pkg::ProtoSctp};
    case ({v6_r, has_ports})
      2'b01:   blk_nxt = {16'd0, a1[31:0], a2[31:0], proto_r, 8'd0, p1, p2, 8'h80,
                          312'd0, 64'd128};
      2'b00:   blk_nxt = {16'd0, a1[31:0], a2[31:0], proto_r, 8'd0, 8'h80,
                          344'd0, 64'd96};
      2'b11:   blk_nxt = {16'd0, a1, a2, proto_r, 8'd0, p1, p2, 8'h80,
                          120'd0, 64'd320};
      default: blk_nxt = {16'd0, a1, a2, proto_r, 8'd0, 8'h80,
                          152'd0, 64'd288};
    endcase
  end

  assign v2_nxt = v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blk_r <= blk_nxt;
    end
  end

  assign blk_v = v2_r;
  assign blk   = blk_r;

endmodule

>>> hdl/cid_sha1.sv
// SHA-1 over one block: a load stage, one pipeline stage per round, a final add.
// Depends on cid_pkg.
module cid_sha1 (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         blk_v,
  input  logic [511:0] blk,
  output logic         dig_v,
  output logic [159:0] dig
);

  logic                 v_r   [cid_pkg::Rounds+1];
  cid_pkg::sha_st_t     st_r  [cid_pkg::Rounds+1];
  cid_pkg::sha_win_t    win_r [cid_pkg::Rounds+1];
  logic                 fin_v_r;
  logic [159:0]         fin_r, fin_nxt;
  cid_pkg::sha_win_t    win0;

  // load the message words, word 0 in slot 0
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      win0[k] = blk[511 - 32*k -: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= blk_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= {cid_pkg::H0, cid_pkg::H1, cid_pkg::H2, cid_pkg::H3, cid_pkg::H4};
      win_r[0] <= win0;
    end
  end

  // round stages; the window slides one word per round
  for (genvar g = 0; g < cid_pkg::Rounds; g++) begin : g_rnd
    cid_pkg::sha_st_t  st_nxt;
    cid_pkg::sha_win_t win_nxt;

    always_comb begin
      st_nxt = cid_pkg::sha_round(st_r[g], win_r[g][0], g);
      for (int k = 0; k < 15; k++) begin
        win_nxt[k] = win_r[g][k+1];
      end
      win_nxt[15] = cid_pkg::rotl(win_r[g][13] ^ win_r[g][8] ^ win_r[g][2]
                                  ^ win_r[g][0], 1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else if (en) begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g+1]  <= st_nxt;
        win_r[g+1] <= win_nxt;
      end
    end
  end

  // add the initial chaining value
  assign fin_nxt = {st_r[cid_pkg::Rounds].a + cid_pkg::H0,
                    st_r[cid_pkg::Rounds].b + cid_pkg::H1,
                    st_r[cid_pkg::Rounds].c + cid_pkg::H2,
                    st_r[cid_pkg::Rounds].d + cid_pkg::H3,
                    st_r[cid_pkg::Rounds].e + cid_pkg::H4};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= v_r[cid_pkg::Rounds];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  assign dig_v = fin_v_r;
  assign dig   = fin_r;

endmodule

>>> hdl/cid_b64.sv
// Output serialiser: "1:" then the base64 digest, one character per word.
// Depends on cid_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cid_b64 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               dig_v,
  input  logic [159:0]       dig,
  output logic               dig_rdy,
  output logic               out_valid,
  input  logic               out_ready,
  output cid_pkg::out_word_t out_data
);

  logic         busy_r, busy_nxt;
  logic [4:0]   cnt_r, cnt_nxt;
  logic [161:0] sh_r, sh_nxt;
  logic         take, at_last, load;

  assign take    = busy_r & out_ready;
  assign at_last = cnt_r == 5'(cid_pkg::IdLen - 1);
  assign dig_rdy = !busy_r || (take && at_last);
  assign load    = dig_v & dig_rdy;

  // next state
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    if (take) begin
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r >= 5'd2) sh_nxt = {sh_r[155:0], 6'd0};
      if (at_last) busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      sh_nxt   = {dig, 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  // character select
  always_comb begin
    case (cnt_r)
      5'd0:    out_data.char_out = cid_pkg::CharOne;
      5'd1:    out_data.char_out = cid_pkg::CharColon;
      5'(cid_pkg::IdLen - 1): out_data.char_out = cid_pkg::CharPad;
      default: out_data.char_out = cid_pkg::b64_char(sh_r[161:156]);
    endcase
    out_data.last = at_last;
  end

  assign out_valid = busy_r;

  `ASSERT_IMP(a_cnt_range, busy_r, cnt_r < 5'(cid_pkg::IdLen), "count past end")
  `ASSERT_NXT(a_last_ends, take && at_last && !dig_v, !busy_r, "busy after last word")
  `ASSERT_NXT(a_stall_hold, busy_r && !out_ready, $stable(cnt_r) && busy_r,
              "count moved while stalled")

endmodule

>>> tb/community_id_flow_hash_tb.sv
// Testbench for the Community ID v1 flow hash: random and directed flow tuples,
// each predicted to its 30-character ID string and checked word by word.
// Depends on cid_pkg and community_id_flow_hash.
`timescale 1ns / 100ps

module community_id_flow_hash_tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  cid_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cid_pkg::out_word_t out_data;

  cid_pkg::in_word_t  pending_tuples[$];
  cid_pkg::out_word_t expected_chars[$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  bit        stim_done = 1'b0;
  bit        hold_off = 1'b0;

  localparam int WatchdogLimit = 20000;

  community_id_flow_hash i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [7:0] b64_of(logic [5:0] v);
    string alpha;
    alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    return alpha[v];
  endfunction

  // ICMP pairing: returns {one_way, partner port}
  function automatic logic [16:0] icmp_partner(bit v6, logic [7:0] ty, logic [7:0] code);
    if (!v6) begin
      case (ty)
        8: return {1'b0, 16'd0};    0: return {1'b0, 16'd8};
        13: return {1'b0, 16'd14};  14: return {1'b0, 16'd13};
        15: return {1'b0, 16'd16};  16: return {1'b0, 16'd15};
        10: return {1'b0, 16'd9};   9: return {1'b0, 16'd10};
        17: return {1'b0, 16'd18};  18: return {1'b0, 16'd17};
        default: return {1'b1, 8'd0, code};
      endcase
    end else begin
      case (ty)
        128: return {1'b0, 16'd129}; 129: return {1'b0, 16'd128};
        133: return {1'b0, 16'd134}; 134: return {1'b0, 16'd133};
        135: return {1'b0, 16'd136}; 136: return {1'b0, 16'd135};
        130: return {1'b0, 16'd131}; 131: return {1'b0, 16'd130};
        139: return {1'b0, 16'd140}; 140: return {1'b0, 16'd139};
        144: return {1'b0, 16'd145}; 145: return {1'b0, 16'd144};
        default: return {1'b1, 8'd0, code};
      endcase
    end
  endfunction

  // Build the hashed message, run SHA-1 and queue the 30 ID characters
  task automatic predict_id(cid_pkg::in_word_t t);
    logic [7:0]   msg[64];
    logic [31:0]  w[80];
    logic [31:0]  h[5];
    logic [31:0]  a, b, c, d, e, f, k, tmp;
    logic [7:0]   dig[20];
    logic [127:0] sa, da, first_a, second_a;
    logic [16:0]  pr;
    logic [15:0]  sp, dp, p1, p2;
    logic [23:0]  g;
    logic [63:0]  bitlen;
    logic [7:0]   id[30];
    bit           one_way, keep, less;
    int           n, alen;
    cid_pkg::out_word_t ow;
    one_way = 1'b0;
    sp = t.src_port_in;
    dp = t.dst_port_in;
    if ((!t.is_ipv6 && t.ip_proto == cid_pkg::ProtoIcmp) ||
        (t.is_ipv6 && t.ip_proto == cid_pkg::ProtoIcmp6)) begin
      pr = icmp_partner(t.is_ipv6, t.icmp_type_in, t.icmp_code_in);
      sp = {8'd0, t.icmp_type_in};
      dp = pr[15:0];
      one_way = pr[16];
    end else if (t.ip_proto != cid_pkg::ProtoTcp && t.ip_proto != cid_pkg::ProtoUdp &&
                 t.ip_proto != cid_pkg::ProtoSctp) begin
      sp = '0;
      dp = '0;
    end
    if (t.is_ipv6) begin
      sa = {t.src_addr_high, t.src_addr_low};
      da = {t.dst_addr_high, t.dst_addr_low};
      alen = 16;
    end else begin
      sa = {96'd0, t.src_addr_low[31:0]};
      da = {96'd0, t.dst_addr_low[31:0]};
      alen = 4;
    end
    less = (sa != da) ? (sa < da) : (sp < dp);
    keep = one_way || less;
    first_a = keep ? sa : da;
    second_a = keep ? da : sa;
    p1 = keep ? sp : dp;
    p2 = keep ? dp : sp;
    foreach (msg[i]) msg[i] = 8'h00;
    n = 2;
    for (int i = alen - 1; i >= 0; i--) msg[n++] = first_a[8*i +: 8];
    for (int i = alen - 1; i >= 0; i--) msg[n++] = second_a[8*i +: 8];
    msg[n++] = t.ip_proto;
    msg[n++] = 8'h00;
    if (t.ip_proto inside {cid_pkg::ProtoIcmp, cid_pkg::ProtoTcp, cid_pkg::ProtoUdp,
                           cid_pkg::ProtoIcmp6, cid_pkg::ProtoSctp}) begin
      msg[n++] = p1[15:8]; msg[n++] = p1[7:0];
      msg[n++] = p2[15:8]; msg[n++] = p2[7:0];
    end
    msg[n] = 8'h80;
    bitlen = 64'(n) * 64'd8;
    for (int i = 0; i < 8; i++) msg[56 + i] = bitlen[8*(7-i) +: 8];
    for (int i = 0; i < 16; i++)
      w[i] = {msg[4*i], msg[4*i+1], msg[4*i+2], msg[4*i+3]};
    for (int i = 16; i < 80; i++) w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    h[0] = cid_pkg::H0; h[1] = cid_pkg::H1; h[2] = cid_pkg::H2;
    h[3] = cid_pkg::H3; h[4] = cid_pkg::H4;
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin f = (b & c) | (~b & d); k = 32'h5A827999; end
      else if (i < 40) begin f = b ^ c ^ d; k = 32'h6ED9EBA1; end
      else if (i < 60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC; end
      else begin f = b ^ c ^ d; k = 32'hCA62C1D6; end
      tmp = rol32(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol32(b, 30); b = a; a = tmp;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++) dig[4*i+j] = h[i][8*(3-j) +: 8];
    id[0] = cid_pkg::CharOne;
    id[1] = cid_pkg::CharColon;
    n = 2;
    for (int i = 0; i < 18; i += 3) begin
      g = {dig[i], dig[i+1], dig[i+2]};
      id[n++] = b64_of(g[23:18]); id[n++] = b64_of(g[17:12]);
      id[n++] = b64_of(g[11:6]);  id[n++] = b64_of(g[5:0]);
    end
    g = {dig[18], dig[19], 8'h00};
    id[n++] = b64_of(g[23:18]); id[n++] = b64_of(g[17:12]);
    id[n++] = b64_of(g[11:6]);  id[n++] = cid_pkg::CharPad;
    for (int i = 0; i < 30; i++) begin
      ow.char_out = id[i];
      ow.last = (i == 29);
      expected_chars.push_back(ow);
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random tuple: mostly the interesting protocols, some wild ones
  function automatic cid_pkg::in_word_t rand_tuple();
    cid_pkg::in_word_t t;
    int sel;
    t.is_ipv6 = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: t.ip_proto = cid_pkg::ProtoTcp;
      2:    t.ip_proto = cid_pkg::ProtoUdp;
      3:    t.ip_proto = cid_pkg::ProtoSctp;
      4, 5: t.ip_proto = t.is_ipv6 ? cid_pkg::ProtoIcmp6 : cid_pkg::ProtoIcmp;
      6:    t.ip_proto = t.is_ipv6 ? cid_pkg::ProtoIcmp : cid_pkg::ProtoIcmp6;
      default: t.ip_proto = 8'($urandom_range(0, 255));
    endcase
    t.src_addr_high = rand64();
    t.src_addr_low = rand64();
    t.dst_addr_high = rand64();
    t.dst_addr_low = rand64();
    // same-address, same-upper and same-IPv4-address cases so ports break ties
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      t.dst_addr_high = t.src_addr_high;
      t.dst_addr_low = t.src_addr_low;
    end else if (sel == 1) begin
      t.dst_addr_high = t.src_addr_high;
    end else if (sel == 2) begin
      t.dst_addr_low[31:0] = t.src_addr_low[31:0];
    end
    t.src_port_in = 16'($urandom);
    t.dst_port_in = ($urandom_range(0, 7) == 0) ? t.src_port_in : 16'($urandom);
    sel = $urandom_range(0, 3);
    if (sel == 0) t.icmp_type_in = 8'($urandom_range(0, 255));
    else if (sel == 1) t.icmp_type_in = 8'($urandom_range(0, 18));
    else t.icmp_type_in = 8'($urandom_range(128, 145));
    t.icmp_code_in = 8'($urandom);
    return t;
  endfunction

  // Stimulus
  initial begin
    cid_pkg::in_word_t t;
    // extremes: all zero, all ones, each protocol
    t = '0; pending_tuples.push_back(t);
    t = '1; pending_tuples.push_back(t);
    t = '1; t.is_ipv6 = 1'b0; pending_tuples.push_back(t);
    for (int v = 0; v < 2; v++) begin
      t = '1; t.is_ipv6 = 1'(v); t.ip_proto = cid_pkg::ProtoTcp; pending_tuples.push_back(t);
      t = '0; t.is_ipv6 = 1'(v); t.ip_proto = cid_pkg::ProtoUdp;
      t.src_port_in = 16'hFFFF; pending_tuples.push_back(t);
      t = rand_tuple(); t.is_ipv6 = 1'(v); t.ip_proto = cid_pkg::ProtoSctp;
      pending_tuples.push_back(t);
      // ICMP paired, one-way, and the wrong ICMP for the family
      t = rand_tuple(); t.is_ipv6 = 1'(v);
      t.ip_proto = v ? cid_pkg::ProtoIcmp6 : cid_pkg::ProtoIcmp;
      t.icmp_type_in = v ? 8'd128 : 8'd8; pending_tuples.push_back(t);
      t.icmp_type_in = v ? 8'd145 : 8'd0; pending_tuples.push_back(t);
      t.icmp_type_in = 8'd3; pending_tuples.push_back(t);
      t.icmp_type_in = 8'hFF; t.icmp_code_in = 8'hFF; pending_tuples.push_back(t);
      t = rand_tuple(); t.is_ipv6 = 1'(v);
      t.ip_proto = v ? cid_pkg::ProtoIcmp : cid_pkg::ProtoIcmp6;
      pending_tuples.push_back(t);
      // equal addresses, ports decide order
      t = rand_tuple(); t.is_ipv6 = 1'(v); t.ip_proto = cid_pkg::ProtoTcp;
      t.dst_addr_high = t.src_addr_high; t.dst_addr_low = t.src_addr_low;
      t.src_port_in = 16'd80; t.dst_port_in = 16'd1024; pending_tuples.push_back(t);
      t.src_port_in = 16'd1024; t.dst_port_in = 16'd80; pending_tuples.push_back(t);
      // other protocol: zero ports, none appended
      t = rand_tuple(); t.is_ipv6 = 1'(v); t.ip_proto = 8'd47; pending_tuples.push_back(t);
    end
    for (int i = 0; i < 460; i++) pending_tuples.push_back(rand_tuple());
    stim_done = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver
  int drv_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_id(in_data);
        drv_gap = gap_len();
      end
      if (!in_valid || in_ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (pending_tuples.size() > 0) begin
          in_data <= pending_tuples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off early in the run
  int rx_count = 0;
  int rx_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      rx_count++;
      if (rx_count == 600) hold_off = 1'b1;
      if (rx_count == 2600) hold_off = 1'b0;
      if (hold_off) out_ready <= 1'b0;
      else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    cid_pkg::out_word_t ew;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected word: char_out %h last %b", out_data.char_out, out_data.last);
        fail_count++;
      end else begin
        ew = expected_chars.pop_front();
        if (out_data.char_out !== ew.char_out) begin
          $error("char_out: expected %h, actual %h", ew.char_out, out_data.char_out);
          fail_count++;
        end
        if (out_data.last !== ew.last) begin
          $error("last: expected %b, actual %b", ew.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog and end of run
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
      if (stim_done && pending_tuples.size() == 0 && !in_valid &&
          expected_chars.size() == 0) begin
        repeat (200) @(posedge clk);
        if (fail_count == 0 && expected_chars.size() == 0) begin
          $display("All tests passed");
        end else begin
          $display("Some tests failed");
        end
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/cid_pkg.sv
hdl/cid_prep.sv
hdl/cid_sha1.sv
hdl/cid_b64.sv
hdl/community_id_flow_hash.sv
tb/community_id_flow_hash_tb.sv
